FILE: design/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg - shared types and constants of the fifo replacement cache
// Default sizes, register reset values and the status struct that the
// lookup pipeline hands to the top level.
// ----------------------------------------------------------------------------
package frc_pkg;

	// default geometry
	localparam int RING_DEPTH_DEF = 128;
	localparam int WORD_BITS_DEF  = 10;

	// capacity register
	localparam int         CAP_W     = 8;
	localparam logic [7:0] CAP_RESET = 8'd128;

	// miss counter width
	localparam int MISS_W = 32;

	// result queue depth, covers the beats in flight in the pipeline
	localparam int Q_DEPTH = 4;

	// pipeline status toward the top level
	typedef struct packed {
		logic clearing;
		logic s1_valid;
		logic s2_valid;
	} frc_stat_t;

endpackage

FILE: design/frc_ram.sv
// ----------------------------------------------------------------------------
// frc_ram - generic simple dual port ram
// One write port, one read port with registered read data; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module frc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/frc_out_queue.sv
// ----------------------------------------------------------------------------
// frc_out_queue - small result queue on the master side
// Holds finished result beats until the downstream takes them and reports
// its fill level so the input side can keep room for beats in flight.
// ----------------------------------------------------------------------------
module frc_out_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = frc_pkg::Q_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic                       out_valid,
	output logic [WIDTH-1:0]           out_data,
	output logic [$clog2(DEPTH+1)-1:0] fill
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign fill      = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// the input side credit check keeps the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("result queue pushed while full");

endmodule

FILE: design/frc_lookup.sv
// ----------------------------------------------------------------------------
// frc_lookup - presence lookup and ring update pipeline
// s1 reads the slot memory, s2 reads the ring at that slot and at the
// oldest slot, decides hit or miss with forwarding from the two previous
// commits, and updates pointers, fill level and miss counter.
// ----------------------------------------------------------------------------
module frc_lookup #(
	parameter int RING_DEPTH = frc_pkg::RING_DEPTH_DEF,
	parameter int WORD_BITS  = frc_pkg::WORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_accept,
	input  logic [WORD_BITS-1:0]                  in_word,
	input  logic [$clog2(RING_DEPTH+1)-1:0]       eff_cap,
	output frc_pkg::frc_stat_t                    stat,
	output logic                                  res_valid,
	output logic [2+WORD_BITS+frc_pkg::MISS_W-1:0] res_data
);

	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int DIST_W     = IDX_W + 1;
	localparam int PRES_DEPTH = 1 << WORD_BITS;
	localparam int MISS_W     = frc_pkg::MISS_W;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);
	localparam logic [DIST_W-1:0] DEPTH_EXT = DIST_W'(RING_DEPTH);

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
	endfunction

	// pipeline registers
	logic                 s1_valid;
	logic [WORD_BITS-1:0] word_s1;
	logic                 s2_valid;
	logic [WORD_BITS-1:0] word_s2;
	logic [IDX_W-1:0]     slot_s2;

	// cache state
	logic [IDX_W-1:0]  oldest_q;
	logic [IDX_W-1:0]  newest_q;
	logic [CNT_W-1:0]  count_q;
	logic [MISS_W-1:0] miss_q;

	// appends held in the c1 and c2 registers, not yet visible in the memories
	logic                 c1_valid_q;
	logic [WORD_BITS-1:0] c1_word_q;
	logic [IDX_W-1:0]     c1_slot_q;
	logic                 c2_valid_q;
	logic [WORD_BITS-1:0] c2_word_q;
	logic [IDX_W-1:0]     c2_slot_q;

	// clearing pass over the slot memory
	logic                 clr_active_q;
	logic [WORD_BITS-1:0] clr_addr_q;

	// memory read data
	logic [IDX_W-1:0]     pres_slot;
	logic [WORD_BITS-1:0] ring_at_slot;
	logic [WORD_BITS-1:0] ring_at_oldest;

	// s2 decision
	logic                 c1_match;
	logic                 c2_match;
	logic [IDX_W-1:0]     sel_slot;
	logic [WORD_BITS-1:0] sel_val;
	logic [DIST_W-1:0]    slot_dist;
	logic                 live;
	logic                 hit;
	logic                 miss;
	logic                 evict;
	logic [WORD_BITS-1:0] evicted_word;
	logic [IDX_W-1:0]     oldest_next;
	logic [IDX_W-1:0]     newest_next;
	logic [MISS_W-1:0]    miss_next;

	// slot memory write port, shared by clearing pass and appends
	logic                 pres_we;
	logic [WORD_BITS-1:0] pres_waddr;
	logic [IDX_W-1:0]     pres_wdata;

	// resolve the slot that holds the word, newest information first
	always_comb begin
		c1_match = c1_valid_q && (c1_word_q == word_s2);
		c2_match = c2_valid_q && (c2_word_q == word_s2);
		if (c1_match) begin
			sel_slot = c1_slot_q;
		end else if (c2_match) begin
			sel_slot = c2_slot_q;
		end else begin
			sel_slot = slot_s2;
		end
		if (c1_valid_q && (c1_slot_q == sel_slot)) begin
			sel_val = c1_word_q;
		end else if (c2_match) begin
			sel_val = c2_word_q;
		end else begin
			sel_val = ring_at_slot;
		end
	end

	// distance of the slot from the oldest entry, live when below the fill level
	always_comb begin
		if (sel_slot >= oldest_q) begin
			slot_dist = {1'b0, sel_slot} - {1'b0, oldest_q};
		end else begin
			slot_dist = {1'b0, sel_slot} + DEPTH_EXT - {1'b0, oldest_q};
		end
		live = (slot_dist < DIST_W'(count_q));
	end

	// hit, miss and eviction
	always_comb begin
		hit   = s2_valid && live && (sel_val == word_s2);
		miss  = s2_valid && !hit;
		evict = miss && (count_q >= eff_cap) && (count_q != '0);
		if (!evict) begin
			evicted_word = '0;
		end else if (c1_valid_q && (c1_slot_q == oldest_q)) begin
			evicted_word = c1_word_q;
		end else begin
			evicted_word = ring_at_oldest;
		end
		oldest_next = evict ? ring_inc(oldest_q) : oldest_q;
		newest_next = miss ? ring_inc(newest_q) : newest_q;
		if (miss && (miss_q != {MISS_W{1'b1}})) begin
			miss_next = miss_q + MISS_W'(1);
		end else begin
			miss_next = miss_q;
		end
	end

	// result beat
	assign res_valid = s2_valid;
	assign res_data  = {miss_next, evicted_word, evict, hit};

	assign stat.clearing = clr_active_q;
	assign stat.s1_valid = s1_valid;
	assign stat.s2_valid = s2_valid;

	// slot memory write select
	assign pres_we    = clr_active_q || miss;
	assign pres_waddr = clr_active_q ? clr_addr_q : word_s2;
	assign pres_wdata = clr_active_q ? '0 : newest_next;

	// word to slot memory
	frc_ram #(
		.WIDTH (IDX_W),
		.DEPTH (PRES_DEPTH)
	) u_pres_ram (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_waddr),
		.wdata (pres_wdata),
		.raddr (in_word),
		.rdata (pres_slot)
	);

	// ring copy read at the candidate slot
	frc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (RING_DEPTH)
	) u_ring_hit_ram (
		.clk   (clk),
		.we    (miss),
		.waddr (newest_next),
		.wdata (word_s2),
		.raddr (pres_slot),
		.rdata (ring_at_slot)
	);

	// ring copy read at the oldest slot
	frc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (RING_DEPTH)
	) u_ring_old_ram (
		.clk   (clk),
		.we    (miss),
		.waddr (newest_next),
		.wdata (word_s2),
		.raddr (oldest_next),
		.rdata (ring_at_oldest)
	);

	// pipeline payload
	always_ff @(posedge clk) begin
		word_s1 <= in_word;
		word_s2 <= word_s1;
		slot_s2 <= pres_slot;
		c1_word_q <= word_s2;
		c1_slot_q <= newest_next;
		c2_word_q <= c1_word_q;
		c2_slot_q <= c1_slot_q;
	end

	// control and cache state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			s2_valid     <= 1'b0;
			oldest_q     <= '0;
			newest_q     <= LAST_IDX;
			count_q      <= '0;
			miss_q       <= '0;
			c1_valid_q   <= 1'b0;
			c2_valid_q   <= 1'b0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			s1_valid   <= in_accept;
			s2_valid   <= s1_valid;
			oldest_q   <= oldest_next;
			newest_q   <= newest_next;
			count_q    <= count_q + CNT_W'(miss) - CNT_W'(evict);
			miss_q     <= miss_next;
			c1_valid_q <= miss;
			c2_valid_q <= c1_valid_q;
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + WORD_BITS'(1);
				if (clr_addr_q == {WORD_BITS{1'b1}}) begin
					clr_active_q <= 1'b0;
				end
			end
		end
	end

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> !evict && (evicted_word == '0) && (miss_next == miss_q))
		else $error("hit changed eviction or miss state");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		miss |=> (count_q != '0) && (count_q <= CNT_W'(RING_DEPTH)))
		else $error("fill level out of range after a miss");

	a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_accept)
		else $error("input beat taken during clearing pass");

endmodule

FILE: design/fifo_replacement_cache.sv
// ----------------------------------------------------------------------------
// fifo_replacement_cache - fifo replacement cache of lookup words
// A result beat is registered in s1, s2 and the result queue before it is
// offered. Throughput: one beat per cycle while the queue has room and no
// clearing pass runs; s1 reads the word-to-slot ram, s2 reads both ring
// copies and forwards the last two appends. Reset: control state resets,
// then a clearing pass sweeps the slot ram; no beat is taken until it ends.
// ----------------------------------------------------------------------------
module fifo_replacement_cache #(
	parameter int RING_DEPTH = frc_pkg::RING_DEPTH_DEF,
	parameter int WORD_BITS  = frc_pkg::WORD_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_wr_en,
	input  logic [frc_pkg::CAP_W-1:0]                        cfg_wr_data,
	input  logic                                             s_axis_tvalid,
	output logic                                             s_axis_tready,
	// lookup_word
	input  logic [((WORD_BITS+7)/8)*8-1:0]                   s_axis_tdata,
	output logic                                             m_axis_tvalid,
	input  logic                                             m_axis_tready,
	// hit, evict_valid, evicted_word, miss_total
	output logic [((2+WORD_BITS+frc_pkg::MISS_W+7)/8)*8-1:0] m_axis_tdata
);

	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > frc_pkg::CAP_W) ? CNT_W : frc_pkg::CAP_W;
	localparam int RES_W  = 2 + WORD_BITS + frc_pkg::MISS_W;
	localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
	localparam int QC_W   = $clog2(frc_pkg::Q_DEPTH + 1);
	localparam int CAP_RST_I = (RING_DEPTH < int'(frc_pkg::CAP_RESET)) ?
		RING_DEPTH : int'(frc_pkg::CAP_RESET);
	localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CAP_RST_I);

	logic [CNT_W-1:0]   eff_cap_q;
	logic [CMP_W-1:0]   cap_ext;
	logic [CNT_W-1:0]   cap_clip;
	frc_pkg::frc_stat_t stat;
	logic               in_accept;
	logic               res_valid;
	logic [RES_W-1:0]   res_data;
	logic [RES_W-1:0]   q_data;
	logic [QC_W-1:0]    q_fill;
	logic [QC_W-1:0]    in_flight;

	// capacity clipped to one .. ring depth
	always_comb begin
		cap_ext = CMP_W'(cfg_wr_data);
		if (cap_ext == '0) begin
			cap_clip = CNT_W'(1);
		end else if (cap_ext > CMP_W'(RING_DEPTH)) begin
			cap_clip = CNT_W'(RING_DEPTH);
		end else begin
			cap_clip = cap_ext[CNT_W-1:0];
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_cap_q <= CAP_RST;
		end else if (cfg_wr_en) begin
			eff_cap_q <= cap_clip;
		end
	end

	// take a beat only when the queue has room for everything in flight
	assign in_flight     = q_fill + QC_W'(stat.s1_valid) + QC_W'(stat.s2_valid);
	assign s_axis_tready = !stat.clearing && (in_flight < QC_W'(frc_pkg::Q_DEPTH));
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	frc_lookup #(
		.RING_DEPTH (RING_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_word   (s_axis_tdata[WORD_BITS-1:0]),
		.eff_cap   (eff_cap_q),
		.stat      (stat),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	frc_out_queue #(
		.WIDTH (RES_W),
		.DEPTH (frc_pkg::Q_DEPTH)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.pop       (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (q_data),
		.fill      (q_fill)
	);

	assign m_axis_tdata = OUT_W'(q_data);

endmodule
